// File: hdl/base85_line_decoder_assert.svh
// ----------------------------------------------------------------------------
// base85 line decoder assertion macros
// shared property forms for the decoder checks, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BASE85_LINE_DECODER_ASSERT_SVH
`define BASE85_LINE_DECODER_ASSERT_SVH

// same-cycle implication
`define B85_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B85_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/b85_pkg.sv
// ----------------------------------------------------------------------------
// b85_pkg
// shared types, codes and the digit table of the base85 line decoder
// ----------------------------------------------------------------------------
package b85_pkg;

	localparam int CMD_DEPTH_DEF = 4;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_CHAR = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;
	localparam status_t ST_BAD_LEN  = 2'd3;

	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	localparam logic [6:0] DIG_UPPER_BASE = 7'd10;
	localparam logic [6:0] DIG_LOWER_BASE = 7'd36;
	localparam logic [5:0] LEN_UPPER_BASE = 6'd1;
	localparam logic [5:0] LEN_LOWER_BASE = 6'd27;
	localparam logic [6:0] RADIX          = 7'd85;
	localparam logic [2:0] GROUP_LAST     = 3'd4;
	localparam logic [5:0] WORD_BYTES     = 6'd4;

	// one queued unit of work: a decoded word or an error
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        eol;
		status_t     status;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] value;
	} digit_t;

	function automatic digit_t digit_of(input logic [7:0] ch);
		digit_t d;
		d.ok    = 1'b1;
		d.value = 7'd0;
		if (ch >= CH_0 && ch <= CH_9) begin
			d.value = 7'(ch - CH_0);
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			d.value = 7'(ch - CH_UPPER_A) + DIG_UPPER_BASE;
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			d.value = 7'(ch - CH_LOWER_A) + DIG_LOWER_BASE;
		end else begin
			case (ch)
				8'h21: d.value = 7'd62; // !
				8'h23: d.value = 7'd63; // #
				8'h24: d.value = 7'd64; // $
				8'h25: d.value = 7'd65; // %
				8'h26: d.value = 7'd66; // &
				8'h28: d.value = 7'd67; // (
				8'h29: d.value = 7'd68; // )
				8'h2A: d.value = 7'd69; // *
				8'h2B: d.value = 7'd70; // +
				8'h2D: d.value = 7'd71; // -
				8'h3B: d.value = 7'd72; // ;
				8'h3C: d.value = 7'd73; // <
				8'h3D: d.value = 7'd74; // =
				8'h3E: d.value = 7'd75; // >
				8'h3F: d.value = 7'd76; // ?
				8'h40: d.value = 7'd77; // @
				8'h5E: d.value = 7'd78; // ^
				8'h5F: d.value = 7'd79; // _
				8'h60: d.value = 7'd80; // backtick
				8'h7B: d.value = 7'd81; // {
				8'h7C: d.value = 7'd82; // |
				8'h7D: d.value = 7'd83; // }
				8'h7E: d.value = 7'd84; // ~
				default: d.ok = 1'b0;
			endcase
		end
		return d;
	endfunction

endpackage

// File: hdl/b85_front.sv
// ----------------------------------------------------------------------------
// b85_front
// character front end: line length, digit accumulation and error detection
// ----------------------------------------------------------------------------
module b85_front import b85_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] character,
	input  logic       line_start,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [5:0]  rem_q, rem_d;
	logic [31:0] group_q, group_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        skip_q, skip_d;

	digit_t      digit;
	logic [38:0] acc;
	logic        fail;
	status_t     fail_status;
	logic [5:0]  take;

	always_comb begin
		digit = digit_of(character);
		acc   = 39'(group_q) * 39'(RADIX) + 39'(digit.value);
		take  = (rem_q > WORD_BYTES) ? WORD_BYTES : rem_q;

		rem_d       = rem_q;
		group_d     = group_q;
		cnt_d       = cnt_q;
		skip_d      = skip_q;
		fail        = 1'b0;
		fail_status = ST_OK;
		cmd_push    = 1'b0;
		cmd.word    = acc[31:0];
		cmd.nbytes  = take[2:0];
		cmd.eol     = 1'b0;
		cmd.status  = ST_OK;

		if (accept) begin
			if (line_start) begin
				group_d = '0;
				cnt_d   = '0;
				skip_d  = 1'b0;
				if (character >= CH_UPPER_A && character <= CH_UPPER_Z) begin
					rem_d = 6'(character - CH_UPPER_A) + LEN_UPPER_BASE;
				end else if (character >= CH_LOWER_A && character <= CH_LOWER_Z) begin
					rem_d = 6'(character - CH_LOWER_A) + LEN_LOWER_BASE;
				end else begin
					fail        = 1'b1;
					fail_status = ST_BAD_LEN;
				end
			end else if (!skip_q && rem_q != '0) begin
				if (!digit.ok) begin
					fail        = 1'b1;
					fail_status = ST_BAD_CHAR;
				end else if (cnt_q != GROUP_LAST) begin
					group_d = acc[31:0];
					cnt_d   = cnt_q + 3'd1;
				end else if (acc[38:32] != '0) begin
					fail        = 1'b1;
					fail_status = ST_OVERFLOW;
				end else begin
					rem_d    = rem_q - take;
					group_d  = '0;
					cnt_d    = '0;
					skip_d   = (rem_d == '0);
					cmd_push = 1'b1;
					cmd.eol  = (rem_d == '0);
				end
			end
		end

		if (fail) begin
			rem_d      = '0;
			group_d    = '0;
			cnt_d      = '0;
			skip_d     = 1'b1;
			cmd_push   = 1'b1;
			cmd.word   = '0;
			cmd.nbytes = 3'd1;
			cmd.eol    = 1'b1;
			cmd.status = fail_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			group_q <= '0;
			cnt_q   <= '0;
			skip_q  <= 1'b1;
		end else begin
			rem_q   <= rem_d;
			group_q <= group_d;
			cnt_q   <= cnt_d;
			skip_q  <= skip_d;
		end
	end

endmodule

// File: hdl/b85_cmd_fifo.sv
// ----------------------------------------------------------------------------
// b85_cmd_fifo
// short command queue between the front end and the byte serialiser
// ----------------------------------------------------------------------------
module b85_cmd_fifo import b85_pkg::*; #(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: hdl/b85_back.sv
// ----------------------------------------------------------------------------
// b85_back
// byte serialiser: splits queued words into bytes behind an output register
// ----------------------------------------------------------------------------
module b85_back import b85_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] data_byte,
	output logic       last_of_run,
	output logic       end_of_line,
	output status_t    status
);

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q, eol_q;
	status_t    status_q;

	logic       last, advance, cur_free;

	assign last     = ({1'b0, idx_q} + 3'd1) == cur_q.nbytes;
	assign advance  = cur_valid_q && (!out_valid_q || pop);
	assign cur_free = !cur_valid_q || (advance && last);
	assign cmd_pop  = cur_free && !cmd_empty;

	assign empty       = !out_valid_q;
	assign data_byte   = byte_q;
	assign last_of_run = last_q;
	assign end_of_line = eol_q;
	assign status      = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			last_q      <= 1'b0;
			eol_q       <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				byte_q      <= cur_q.word[{~idx_q, 3'b000} +: 8];
				last_q      <= last;
				eol_q       <= last && cur_q.eol;
				status_q    <= cur_q.status;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				cur_q       <= cmd;
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else begin
				if (cur_free) begin
					cur_valid_q <= 1'b0;
				end
				if (advance) begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule

// File: hdl/base85_line_decoder.sv
// ----------------------------------------------------------------------------
// base85_line_decoder
// decodes base85 binary-delta text lines, one character per transaction
// ----------------------------------------------------------------------------
// One character is taken per cycle whenever the command queue between the
// front end and the byte serialiser has room; the front end resolves each
// character with one multiply-accumulate by 85. Bytes leave at one per cycle
// from the serialiser's output register while pop is held and a command is
// queued. A group's result is registered in the command queue, then in the
// serialiser's current command register and then in its output register.
// Error results carry a zero byte with last_of_run and end_of_line set.
module base85_line_decoder import b85_pkg::*; #(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] character,
	input  logic       line_start,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       last_of_run,
	output logic       end_of_line,
	output logic [1:0] status
);

	`include "base85_line_decoder_assert.svh"

	logic accept;
	logic cmd_push, cmd_pop, cmd_full, cmd_empty;
	cmd_t cmd_in, cmd_out;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	b85_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.character  (character),
		.line_start (line_start),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	b85_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	b85_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_out),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.data_byte   (data_byte),
		.last_of_run (last_of_run),
		.end_of_line (end_of_line),
		.status      (status)
	);

	`B85_ASSERT_IMP(a_no_push_when_full, cmd_push, !cmd_full, "command lost on full queue")
	`B85_ASSERT_IMP(a_err_shape, !empty && status != ST_OK, data_byte == 8'd0 && last_of_run && end_of_line, "malformed error transaction")
	`B85_ASSERT_IMP(a_eol_is_last, !empty && end_of_line, last_of_run, "end of line not on last byte of run")
	`B85_ASSERT_NEXT(a_cmd_reaches_back, cmd_push && cmd_empty && !cmd_pop, !cmd_empty, "queued command dropped")

endmodule
